### sv/sgs_pkg.sv
// Package for the sandpile grid stabilizer: command codes, sequencer states, sweep phases, constants.
package sgs_pkg;

	// Command codes carried on op
	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_READ  = 2'd1,
		OP_STAB  = 2'd2,
		OP_IDENT = 2'd3
	} op_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_RDWAIT,
		ST_FILL,
		ST_SWEEP,
		ST_XFORM
	} state_t;

	// Sweep phases: five reads per cell, then a write phase
	typedef enum logic [2:0] {
		PH_CTR   = 3'd0,
		PH_UP    = 3'd1,
		PH_DOWN  = 3'd2,
		PH_LEFT  = 3'd3,
		PH_RIGHT = 3'd4,
		PH_WRITE = 3'd5
	} phase_t;

	localparam logic [7:0]  TOPPLE_MIN = 8'd4;
	localparam logic [7:0]  FILL_VALUE = 8'd6;
	localparam logic [15:0] SWEEP_MAX  = 16'hFFFF;

endpackage

### sv/sandpile_grid_stabilizer_core.sv
// Sandpile grid stabilizer: command sequencer around one double-banked grid memory.
//
// channel  | handshake      | fields
// ---------+----------------+------------------------------
// command  | start / busy   | op, row, col, value
// result   | done (strobe)  | cell_value, sweep_count
//
// Write: result strobe in the next cycle; busy stays low.
// Read: waits in ST_RDWAIT for the registered memory read port.
// Stabilize: per cell per sweep, five reads on the single read port, then one write.
// Identity: fill, stabilize, complement (read, then write back per cell), stabilize again.
// After reset, busy is high while bank 0 is cleared.
// The result strobe is held one cycle; the receiver cannot stall it.
module sandpile_grid_stabilizer_core #(
	parameter int GRID_SIDE = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  op,
	input  logic [3:0]  row,
	input  logic [3:0]  col,
	input  logic [7:0]  value,
	output logic        done,
	output logic [7:0]  cell_value,
	output logic [15:0] sweep_count
);

	localparam int CELLS = GRID_SIDE * GRID_SIDE;
	localparam int IW    = $clog2(CELLS);
	localparam int CW    = $clog2(GRID_SIDE);
	localparam int AW    = IW + 1;
	localparam int DEPTH = 2 ** AW;
	localparam logic [IW-1:0] LAST_IDX = IW'(CELLS - 1);
	localparam logic [IW-1:0] SIDE_IW  = IW'(GRID_SIDE);
	localparam logic [CW-1:0] LAST_RC  = CW'(GRID_SIDE - 1);

	sgs_pkg::state_t state_q, state_d;
	logic [2:0]    ph_q;
	logic [IW-1:0] idx_q;
	logic [CW-1:0] r_q, c_q;
	logic          bank_q;
	logic          any_q;
	logic          pass_q;
	logic          ident_q;
	logic          inside_q;
	logic          vld_s1;
	logic [7:0]    acc_q;
	logic [15:0]   sweeps_q;
	logic [15:0]   sweep_total_q;
	logic          done_q;
	logic [7:0]    cell_q;

	// grid memory: two banks of 2**IW cells (GRID_SIDE^2 in use), bank bit on top
	logic [7:0]    mem [DEPTH];
	logic [7:0]    rdata_q;
	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [7:0]    wdata;

	logic          in_grid;
	logic [IW-1:0] hidx;
	logic          last_cell;
	logic          nb_ok;
	logic          hit;
	logic [15:0]   sweep_inc;

	assign in_grid   = (32'(row) < 32'(GRID_SIDE)) && (32'(col) < 32'(GRID_SIDE));
	assign hidx      = IW'(32'(row) * 32'(GRID_SIDE) + 32'(col));
	assign last_cell = (idx_q == LAST_IDX);
	assign hit       = vld_s1 && (rdata_q >= sgs_pkg::TOPPLE_MIN);
	assign sweep_inc = (sweeps_q == sgs_pkg::SWEEP_MAX) ? sweeps_q : sweeps_q + 16'd1;

	// neighbor lies inside the grid for the read issued this phase
	always_comb begin
		unique case (ph_q)
			sgs_pkg::PH_UP:    nb_ok = (r_q != '0);
			sgs_pkg::PH_DOWN:  nb_ok = (r_q != LAST_RC);
			sgs_pkg::PH_LEFT:  nb_ok = (c_q != '0);
			sgs_pkg::PH_RIGHT: nb_ok = (c_q != LAST_RC);
			default:           nb_ok = 1'b1;
		endcase
	end

	// memory port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sgs_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and memory controls
	always_comb begin
		state_d = state_q;
		we      = 1'b0;
		waddr   = '0;
		wdata   = '0;
		raddr   = {bank_q, idx_q};
		unique case (state_q)
			sgs_pkg::ST_IDLE: begin
				if (start) begin
					unique case (sgs_pkg::op_t'(op))
						sgs_pkg::OP_WRITE: begin
							we    = in_grid;
							waddr = {bank_q, hidx};
							wdata = value;
						end
						sgs_pkg::OP_READ: begin
							raddr   = {bank_q, hidx};
							state_d = sgs_pkg::ST_RDWAIT;
						end
						sgs_pkg::OP_STAB:  state_d = sgs_pkg::ST_SWEEP;
						sgs_pkg::OP_IDENT: state_d = sgs_pkg::ST_FILL;
					endcase
				end
			end
			sgs_pkg::ST_CLEAR: begin
				we    = 1'b1;
				waddr = {1'b0, idx_q};
				if (last_cell) state_d = sgs_pkg::ST_IDLE;
			end
			sgs_pkg::ST_RDWAIT: state_d = sgs_pkg::ST_IDLE;
			sgs_pkg::ST_FILL: begin
				we    = 1'b1;
				waddr = {bank_q, idx_q};
				wdata = sgs_pkg::FILL_VALUE;
				if (last_cell) state_d = sgs_pkg::ST_SWEEP;
			end
			sgs_pkg::ST_SWEEP: begin
				unique case (ph_q)
					sgs_pkg::PH_UP:    raddr = {bank_q, idx_q - SIDE_IW};
					sgs_pkg::PH_DOWN:  raddr = {bank_q, idx_q + SIDE_IW};
					sgs_pkg::PH_LEFT:  raddr = {bank_q, idx_q - IW'(1)};
					sgs_pkg::PH_RIGHT: raddr = {bank_q, idx_q + IW'(1)};
					default:           raddr = {bank_q, idx_q};
				endcase
				if (ph_q == sgs_pkg::PH_WRITE) begin
					we    = 1'b1;
					waddr = {~bank_q, idx_q};
					wdata = acc_q + {7'd0, hit};
					if (last_cell && !any_q) begin
						state_d = (ident_q && !pass_q) ? sgs_pkg::ST_XFORM : sgs_pkg::ST_IDLE;
					end
				end
			end
			sgs_pkg::ST_XFORM: begin
				if (ph_q != sgs_pkg::PH_CTR) begin
					we    = 1'b1;
					waddr = {bank_q, idx_q};
					wdata = sgs_pkg::FILL_VALUE - rdata_q;
					if (last_cell) state_d = sgs_pkg::ST_SWEEP;
				end
			end
			default: state_d = sgs_pkg::ST_IDLE;
		endcase
	end

	// counters, sweep bookkeeping and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q          <= '0;
			idx_q         <= '0;
			r_q           <= '0;
			c_q           <= '0;
			bank_q        <= 1'b0;
			any_q         <= 1'b0;
			pass_q        <= 1'b0;
			ident_q       <= 1'b0;
			inside_q      <= 1'b0;
			vld_s1        <= 1'b0;
			acc_q         <= '0;
			sweeps_q      <= '0;
			sweep_total_q <= '0;
			done_q        <= 1'b0;
			cell_q        <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				sgs_pkg::ST_IDLE: begin
					ph_q     <= '0;
					idx_q    <= '0;
					r_q      <= '0;
					c_q      <= '0;
					any_q    <= 1'b0;
					pass_q   <= 1'b0;
					sweeps_q <= '0;
					inside_q <= in_grid;
					ident_q  <= (sgs_pkg::op_t'(op) == sgs_pkg::OP_IDENT);
					if (start && (sgs_pkg::op_t'(op) == sgs_pkg::OP_WRITE)) begin
						done_q <= 1'b1;
						cell_q <= '0;
					end
				end
				sgs_pkg::ST_CLEAR, sgs_pkg::ST_FILL: begin
					idx_q <= last_cell ? '0 : idx_q + IW'(1);
				end
				sgs_pkg::ST_RDWAIT: begin
					done_q <= 1'b1;
					cell_q <= inside_q ? rdata_q : '0;
				end
				sgs_pkg::ST_SWEEP: begin
					vld_s1 <= nb_ok;
					if (ph_q == sgs_pkg::PH_UP) begin
						// center value arrives
						acc_q <= (rdata_q >= sgs_pkg::TOPPLE_MIN) ?
							rdata_q - sgs_pkg::TOPPLE_MIN : rdata_q;
						if (rdata_q >= sgs_pkg::TOPPLE_MIN) any_q <= 1'b1;
					end else if (ph_q != sgs_pkg::PH_CTR) begin
						acc_q <= acc_q + {7'd0, hit};
					end
					if (ph_q == sgs_pkg::PH_WRITE) begin
						ph_q <= '0;
						if (last_cell) begin
							idx_q    <= '0;
							r_q      <= '0;
							c_q      <= '0;
							bank_q   <= ~bank_q;
							any_q    <= 1'b0;
							sweeps_q <= sweep_inc;
							if (!any_q) begin
								if (!(ident_q && !pass_q)) begin
									done_q        <= 1'b1;
									cell_q        <= '0;
									sweep_total_q <= sweep_inc;
								end
							end
						end else begin
							idx_q <= idx_q + IW'(1);
							if (c_q == LAST_RC) begin
								c_q <= '0;
								r_q <= r_q + CW'(1);
							end else begin
								c_q <= c_q + CW'(1);
							end
						end
					end else begin
						ph_q <= ph_q + 3'd1;
					end
				end
				sgs_pkg::ST_XFORM: begin
					if (ph_q == sgs_pkg::PH_CTR) begin
						ph_q <= sgs_pkg::PH_UP;
					end else begin
						ph_q <= '0;
						if (last_cell) begin
							idx_q    <= '0;
							pass_q   <= 1'b1;
							sweeps_q <= '0;
							any_q    <= 1'b0;
						end else begin
							idx_q <= idx_q + IW'(1);
						end
					end
				end
				default: ph_q <= '0;
			endcase
		end
	end

	assign busy        = (state_q != sgs_pkg::ST_IDLE);
	assign done        = done_q;
	assign cell_value  = cell_q;
	assign sweep_count = sweep_total_q;

	// sweep writes always land in the bank not being read
	a_bank_split: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sgs_pkg::ST_SWEEP && we) |-> (waddr[AW-1] != bank_q))
		else $error("sweep write hit the current bank");

	// a read command keeps the block busy in its wait state
	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && op == sgs_pkg::OP_READ) |=> (busy && !done))
		else $error("read did not wait for memory data");

	// no result leaves while a fill or complement pass is under way
	a_no_early_done: assert property (@(posedge clk) disable iff (!arst_n)
		($past(state_q) == sgs_pkg::ST_FILL || $past(state_q) == sgs_pkg::ST_XFORM)
		|-> !done)
		else $error("result strobe during identity sequence");

endmodule

### verif/sandpile_grid_stabilizer_core_tb.sv
// Self-checking testbench for the sandpile grid stabilizer core.
module sandpile_grid_stabilizer_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SIDE = 16;
	localparam int CELLS = SIDE * SIDE;

	typedef struct packed {
		logic [7:0]  cell_value;
		logic [15:0] sweep_count;
	} outcome_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  op;
	logic [3:0]  row;
	logic [3:0]  col;
	logic [7:0]  value;
	logic        done;
	logic [7:0]  cell_value;
	logic [15:0] sweep_count;

	// Predictor state: visible grid and last sweep total
	logic [7:0]  pile[CELLS];
	logic [15:0] last_sweeps;

	outcome_t pending_outcomes[$];
	int mismatches;
	int transfers_sent;
	int outcomes_seen;
	int stab_cmds;
	int ident_cmds;
	bit burst_mode;

	sandpile_grid_stabilizer_core #(.GRID_SIDE(SIDE)) i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.op(op), .row(row), .col(col), .value(value),
		.done(done), .cell_value(cell_value), .sweep_count(sweep_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// True when the cell exists and holds enough sand to topple
	function automatic bit is_unstable(int r, int c);
		if (r < 0 || c < 0 || r >= SIDE || c >= SIDE) begin
			return 1'b0;
		end
		return pile[r * SIDE + c] >= sgs_pkg::TOPPLE_MIN;
	endfunction

	// Synchronous sweeps until one finds nothing to topple
	function automatic void settle_pile();
		logic [7:0] nxt[CELLS];
		int unsigned sweeps;
		bit any;
		int v;
		sweeps = 0;
		do begin
			any = 1'b0;
			for (int r = 0; r < SIDE; r++) begin
				for (int c = 0; c < SIDE; c++) begin
					v = pile[r * SIDE + c];
					if (v >= sgs_pkg::TOPPLE_MIN) begin
						v -= 4;
						any = 1'b1;
					end
					v += is_unstable(r - 1, c) + is_unstable(r + 1, c)
						+ is_unstable(r, c - 1) + is_unstable(r, c + 1);
					nxt[r * SIDE + c] = v[7:0];
				end
			end
			pile = nxt;
			if (sweeps < sgs_pkg::SWEEP_MAX) begin
				sweeps++;
			end
		end while (any);
		last_sweeps = sweeps[15:0];
	endfunction

	function automatic outcome_t predict_outcome(sgs_pkg::op_t o, logic [3:0] r,
			logic [3:0] c, logic [7:0] v);
		outcome_t res;
		res.cell_value = 8'd0;
		case (o)
			sgs_pkg::OP_WRITE: pile[r * SIDE + c] = v;
			sgs_pkg::OP_READ:  res.cell_value = pile[r * SIDE + c];
			sgs_pkg::OP_STAB:  settle_pile();
			default: begin
				foreach (pile[i]) pile[i] = sgs_pkg::FILL_VALUE;
				settle_pile();
				foreach (pile[i]) pile[i] = sgs_pkg::FILL_VALUE - pile[i];
				settle_pile();
			end
		endcase
		res.sweep_count = last_sweeps;
		return res;
	endfunction

	// Send one command; start stays high so back-to-back transfers need no drop
	task automatic send_cmd(sgs_pkg::op_t o, logic [3:0] r, logic [3:0] c, logic [7:0] v);
		int gap;
		gap = burst_mode ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			@(negedge clk);
			start = 1'b0;
			op = 2'($urandom);
			row = 4'($urandom);
			col = 4'($urandom);
			value = 8'($urandom);
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start = 1'b1;
		op = o;
		row = r;
		col = c;
		value = v;
		do @(posedge clk); while (busy);
		pending_outcomes.push_back(predict_outcome(o, r, c, v));
		transfers_sent++;
		if (o == sgs_pkg::OP_STAB) stab_cmds++;
		if (o == sgs_pkg::OP_IDENT) ident_cmds++;
	endtask

	task automatic drop_start();
		@(negedge clk);
		start = 1'b0;
	endtask

	// Compare each result with the oldest expectation
	always @(posedge clk) begin
		outcome_t exp_o;
		if (arst_n && done) begin
			outcomes_seen++;
			if (pending_outcomes.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("unexpected result: cell_value=%0d sweep_count=%0d",
						cell_value, sweep_count);
				end
			end else begin
				exp_o = pending_outcomes.pop_front();
				if (cell_value !== exp_o.cell_value || sweep_count !== exp_o.sweep_count) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("result %0d: expected cell_value=%0d sweep_count=%0d, got %0d %0d",
							outcomes_seen, exp_o.cell_value, exp_o.sweep_count,
							cell_value, sweep_count);
					end
				end
			end
		end
	end

	// Extreme values and addresses, read back
	task automatic test_write_read();
		send_cmd(sgs_pkg::OP_READ, 4'd0, 4'd0, 8'd0);
		send_cmd(sgs_pkg::OP_WRITE, 4'd0, 4'd0, 8'hFF);
		send_cmd(sgs_pkg::OP_WRITE, 4'd15, 4'd15, 8'h00);
		send_cmd(sgs_pkg::OP_WRITE, 4'd15, 4'd0, 8'hAA);
		send_cmd(sgs_pkg::OP_WRITE, 4'd0, 4'd15, 8'h55);
		send_cmd(sgs_pkg::OP_READ, 4'd0, 4'd0, 8'd0);
		send_cmd(sgs_pkg::OP_READ, 4'd15, 4'd0, 8'd0);
		send_cmd(sgs_pkg::OP_READ, 4'd0, 4'd15, 8'd0);
		send_cmd(sgs_pkg::OP_READ, 4'd15, 4'd15, 8'd0);
		send_cmd(sgs_pkg::OP_WRITE, 4'd15, 4'd0, 8'd0);
		send_cmd(sgs_pkg::OP_WRITE, 4'd0, 4'd15, 8'd0);
	endtask

	// Large pile in a corner, single topple in the middle, stable grid
	task automatic test_stabilize();
		send_cmd(sgs_pkg::OP_STAB, 4'd0, 4'd0, 8'd0);
		send_cmd(sgs_pkg::OP_READ, 4'd0, 4'd1, 8'd0);
		send_cmd(sgs_pkg::OP_WRITE, 4'd8, 4'd8, 8'd4);
		send_cmd(sgs_pkg::OP_STAB, 4'd0, 4'd0, 8'd0);
		send_cmd(sgs_pkg::OP_READ, 4'd7, 4'd8, 8'd0);
		send_cmd(sgs_pkg::OP_STAB, 4'd0, 4'd0, 8'd0);
	endtask

	task automatic test_identity();
		send_cmd(sgs_pkg::OP_IDENT, 4'd3, 4'd9, 8'd17);
		send_cmd(sgs_pkg::OP_READ, 4'd0, 4'd0, 8'd0);
		send_cmd(sgs_pkg::OP_READ, 4'd7, 4'd7, 8'd0);
	endtask

	// Mostly small writes and reads; big values are overwritten before any sweep
	task automatic test_random(int n);
		int pick;
		logic [3:0] r;
		logic [3:0] c;
		for (int k = 0; k < n; k++) begin
			if (k % 100 == 0) burst_mode = ($urandom_range(0, 2) == 0);
			pick = $urandom_range(0, 99);
			r = 4'($urandom);
			c = 4'($urandom);
			if (pick < 2) begin
				send_cmd(sgs_pkg::OP_STAB, r, c, 8'($urandom));
			end else if (pick < 7) begin
				send_cmd(sgs_pkg::OP_WRITE, r, c, 8'($urandom));
				send_cmd(sgs_pkg::OP_READ, r, c, 8'($urandom));
				send_cmd(sgs_pkg::OP_WRITE, r, c, 8'($urandom_range(0, 3)));
			end else if (pick < 50) begin
				send_cmd(sgs_pkg::OP_WRITE, r, c, 8'($urandom_range(0, 5)));
			end else begin
				send_cmd(sgs_pkg::OP_READ, r, c, 8'($urandom));
			end
		end
		burst_mode = 1'b0;
		send_cmd(sgs_pkg::OP_STAB, 4'd0, 4'd0, 8'd0);
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		op = sgs_pkg::OP_WRITE;
		row = 4'd0;
		col = 4'd0;
		value = 8'd0;
		mismatches = 0;
		transfers_sent = 0;
		outcomes_seen = 0;
		stab_cmds = 0;
		ident_cmds = 0;
		burst_mode = 1'b0;
		foreach (pile[i]) pile[i] = 8'd0;
		last_sweeps = 16'd0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_write_read();
		test_stabilize();
		test_identity();
		test_random(800);
		drop_start();

		while (pending_outcomes.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		$display("%0d commands sent (%0d stabilize, %0d identity), %0d results checked",
			transfers_sent, stab_cmds, ident_cmds, outcomes_seen);
		$display("%0d mismatches, %0d expectations left", mismatches, pending_outcomes.size());
		if (mismatches == 0 && pending_outcomes.size() == 0) begin
			$display("sandpile_grid_stabilizer_core: match");
		end else begin
			$display("sandpile_grid_stabilizer_core: mismatch");
		end
		$finish;
	end

	// Hang guard
	initial begin
		#1s;
		$display("timeout");
		$display("sandpile_grid_stabilizer_core: mismatch");
		$finish;
	end

endmodule
